@@ sv/ksgc_pkg.sv @@
// Shared types and constants for the sandwich k-mer group classifier.
// No dependencies; every other file of the block refers to it by scoped names.
package ksgc_pkg;

    localparam int FLANK_BASES = 20;
    localparam int FLANK_W     = 2 * FLANK_BASES;
    localparam int COUNT_W     = 16;
    localparam int QSUM_W      = 20;
    localparam int QUAL_W      = 6;
    localparam int NUM_BASES   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [QSUM_W-1:0]  QSUM_MAX  = '1;

    // Reset values of the configuration registers
    localparam logic [QUAL_W-1:0]  MIN_QUALITY_RST       = 6'd3;
    localparam logic [COUNT_W-1:0] MIN_SUPPORT_RST       = 16'd3;
    localparam logic [QSUM_W-1:0]  MIN_QUALITY_TOTAL_RST = 20'd30;
    localparam logic [QSUM_W-1:0]  MAX_QUALITY_TOTAL_RST = 20'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_QUALITY       = 2'd0,
        CFG_MIN_SUPPORT       = 2'd1,
        CFG_MIN_QUALITY_TOTAL = 2'd2,
        CFG_MAX_QUALITY_TOTAL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [FLANK_W-1:0] left_flank;
        logic [FLANK_W-1:0] right_flank;
        logic [1:0]         middle_base;
        logic [QUAL_W-1:0]  base_quality;
        logic               stream_end;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         suspicious_count;
        logic [1:0]         dominant_base;
        logic [COUNT_W-1:0] group_size;
        logic               final_result;
    } out_beat_t;

    typedef struct packed {
        logic [QUAL_W-1:0]  min_quality;
        logic [COUNT_W-1:0] min_support;
        logic [QSUM_W-1:0]  min_quality_total;
        logic [QSUM_W-1:0]  max_quality_total;
    } cfg_t;

    // Per-group accumulators
    typedef struct packed {
        logic [NUM_BASES-1:0][COUNT_W-1:0] counts;
        logic [NUM_BASES-1:0][QSUM_W-1:0]  sums;
    } grp_t;

    // A closed group waiting to be classified
    typedef struct packed {
        grp_t grp;
        logic final_result;
    } group_snap_t;

endpackage

@@ sv/kmer_sandwich_group_classifier.sv @@
// Top level of the sandwich k-mer group classifier.
// Depends on ksgc_pkg, ksgc_accum, ksgc_classify and ksgc_outq.
//
// Usage
//   in channel  (in_valid/in_ready/in_beat): key-sorted records. Consecutive
//     records with equal left and right flanks form one group; a record with
//     different flanks closes the open group, and stream_end closes the group
//     holding the marked record after it is counted.
//   out channel (out_valid/out_ready/out_beat): one beat per closed group;
//     final_result is set on the last beat caused by a given input beat.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//     always ready; write only while the block is idle.
// Path: a result beat passes the snapshot registers and then the result
//   queue before it is offered.
// Throughput: one input beat per cycle while in_ready is high. An input that closes two groups gives
//   two output beats, and the output side drains one beat per cycle.
//   in_ready needs room for two beats in the 4-entry result queue beyond the
//   beats still in the snapshot stage.
// Reset: no group open, registers at their reset values, queue empty; the
//   group accumulators are not reset, but a new group starts from zero.
// Stall: while out_ready is low, the queue fills and in_ready drops; nothing
//   is lost and the offered beat holds.
module kmer_sandwich_group_classifier
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ksgc_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output ksgc_pkg::out_beat_t out_beat,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ksgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ksgc_pkg::CFG_DATA_W-1:0] cfg_data
);

    ksgc_pkg::cfg_t                         cfg_reg;
    logic                                   take;
    logic                                   snap0_valid;
    logic                                   snap1_valid;
    ksgc_pkg::group_snap_t                  snap0;
    ksgc_pkg::group_snap_t                  snap1;
    ksgc_pkg::out_beat_t                    res0;
    ksgc_pkg::out_beat_t                    res1;
    logic [ksgc_pkg::OUTQ_CNT_W-1:0]        level;
    logic [ksgc_pkg::OUTQ_CNT_W:0]          free;
    logic [ksgc_pkg::OUTQ_CNT_W:0]          need;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_quality       <= ksgc_pkg::MIN_QUALITY_RST;
            cfg_reg.min_support       <= ksgc_pkg::MIN_SUPPORT_RST;
            cfg_reg.min_quality_total <= ksgc_pkg::MIN_QUALITY_TOTAL_RST;
            cfg_reg.max_quality_total <= ksgc_pkg::MAX_QUALITY_TOTAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ksgc_pkg::cfg_idx_t'(cfg_index))
                ksgc_pkg::CFG_MIN_QUALITY:
                    cfg_reg.min_quality <= cfg_data[ksgc_pkg::QUAL_W-1:0];
                ksgc_pkg::CFG_MIN_SUPPORT:
                    cfg_reg.min_support <= cfg_data[ksgc_pkg::COUNT_W-1:0];
                ksgc_pkg::CFG_MIN_QUALITY_TOTAL:
                    cfg_reg.min_quality_total <= cfg_data[ksgc_pkg::QSUM_W-1:0];
                ksgc_pkg::CFG_MAX_QUALITY_TOTAL:
                    cfg_reg.max_quality_total <= cfg_data[ksgc_pkg::QSUM_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Flow control: snapshots always drain into the queue the next cycle, so
    // accept only when the queue can absorb those plus two more beats.
    assign free = (ksgc_pkg::OUTQ_CNT_W + 1)'(ksgc_pkg::OUTQ_DEPTH)
                - (ksgc_pkg::OUTQ_CNT_W + 1)'(level);
    assign need = (ksgc_pkg::OUTQ_CNT_W + 1)'(2)
                + (ksgc_pkg::OUTQ_CNT_W + 1)'(snap0_valid)
                + (ksgc_pkg::OUTQ_CNT_W + 1)'(snap1_valid);
    assign in_ready = (free >= need);
    assign take     = in_valid && in_ready;

    // Group accumulation; snap0 is the group closed by a flank change,
    // snap1 the group closed by stream_end.
    ksgc_accum u_accum
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item        (in_beat),
        .min_quality (cfg_reg.min_quality),
        .snap0_valid (snap0_valid),
        .snap0       (snap0),
        .snap1_valid (snap1_valid),
        .snap1       (snap1)
    );

    ksgc_classify u_cls0
    (
        .snap   (snap0),
        .cfg    (cfg_reg),
        .result (res0)
    );

    ksgc_classify u_cls1
    (
        .snap   (snap1),
        .cfg    (cfg_reg),
        .result (res1)
    );

    // Result queue, flank-change result ahead of the stream-end result
    ksgc_outq u_outq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr0   (snap0_valid),
        .data0 (res0),
        .wr1   (snap1_valid),
        .data1 (res1),
        .valid (out_valid),
        .ready (out_ready),
        .data  (out_beat),
        .level (level)
    );

endmodule

@@ sv/ksgc_classify.sv @@
// Classifies one closed group: dominant base, suspicious minority count, size.
// Depends on ksgc_pkg.
module ksgc_classify
(
    input  ksgc_pkg::group_snap_t snap,
    input  ksgc_pkg::cfg_t        cfg,
    output ksgc_pkg::out_beat_t   result
);

    logic [1:0]                           dom;
    logic [ksgc_pkg::NUM_BASES-1:0]       pass;
    logic [2:0]                           sus;
    logic [ksgc_pkg::COUNT_W+1:0]         total;

    always_comb
    begin
        // lowest code wins a tie: strict compare only
        dom = 2'd0;
        if (snap.grp.counts[1] > snap.grp.counts[dom])
        begin
            dom = 2'd1;
        end
        if (snap.grp.counts[2] > snap.grp.counts[dom])
        begin
            dom = 2'd2;
        end
        if (snap.grp.counts[3] > snap.grp.counts[dom])
        begin
            dom = 2'd3;
        end
    end

    always_comb
    begin
        for (int b = 0; b < ksgc_pkg::NUM_BASES; b++)
        begin
            pass[b] = (2'(b) != dom)
                   && (snap.grp.counts[b] >= cfg.min_support)
                   && (snap.grp.sums[b] >= cfg.min_quality_total)
                   && (snap.grp.sums[b] <= cfg.max_quality_total);
        end
    end

    assign sus   = 3'(pass[0]) + 3'(pass[1]) + 3'(pass[2]) + 3'(pass[3]);
    assign total = 18'(snap.grp.counts[0]) + 18'(snap.grp.counts[1])
                 + 18'(snap.grp.counts[2]) + 18'(snap.grp.counts[3]);

    always_comb
    begin
        result.suspicious_count = sus[1:0];
        result.dominant_base    = dom;
        result.group_size       = (total > 18'(ksgc_pkg::COUNT_MAX)) ?
                                  ksgc_pkg::COUNT_MAX : total[ksgc_pkg::COUNT_W-1:0];
        result.final_result     = snap.final_result;
    end

endmodule

@@ sv/ksgc_accum.sv @@
// Open-group tracker: flank compare, saturating count and quality accumulators,
// and the registered snapshots of groups that close. Depends on ksgc_pkg.
module ksgc_accum
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  ksgc_pkg::in_beat_t    item,
    input  logic [ksgc_pkg::QUAL_W-1:0] min_quality,
    output logic                  snap0_valid,
    output ksgc_pkg::group_snap_t snap0,
    output logic                  snap1_valid,
    output ksgc_pkg::group_snap_t snap1
);

    logic                          open_reg;
    logic                          snap0_valid_reg;
    logic                          snap1_valid_reg;
    logic [ksgc_pkg::FLANK_W-1:0]  left_reg;
    logic [ksgc_pkg::FLANK_W-1:0]  right_reg;
    ksgc_pkg::grp_t                grp_reg;
    ksgc_pkg::grp_t                grp_next;
    ksgc_pkg::grp_t                base;
    ksgc_pkg::group_snap_t         snap0_reg;
    ksgc_pkg::group_snap_t         snap1_reg;
    logic                          mismatch;
    logic [ksgc_pkg::QSUM_W:0]     qsum;

    assign mismatch = open_reg && ((item.left_flank != left_reg)
                                || (item.right_flank != right_reg));

    always_comb
    begin
        // closed or new group starts from zero
        base     = (!open_reg || mismatch) ? '0 : grp_reg;
        grp_next = base;
        qsum     = {1'b0, base.sums[item.middle_base]}
                 + (ksgc_pkg::QSUM_W + 1)'(item.base_quality);
        if (base.counts[item.middle_base] != ksgc_pkg::COUNT_MAX)
        begin
            grp_next.counts[item.middle_base] = base.counts[item.middle_base] + 16'd1;
        end
        if (item.base_quality >= min_quality)
        begin
            grp_next.sums[item.middle_base] = qsum[ksgc_pkg::QSUM_W] ?
                ksgc_pkg::QSUM_MAX : qsum[ksgc_pkg::QSUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg        <= 1'b0;
            snap0_valid_reg <= 1'b0;
            snap1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            open_reg        <= !item.stream_end;
            snap0_valid_reg <= mismatch;
            snap1_valid_reg <= item.stream_end;
        end
        else
        begin
            snap0_valid_reg <= 1'b0;
            snap1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_reg  <= item.left_flank;
            right_reg <= item.right_flank;
            grp_reg   <= grp_next;
            snap0_reg <= '{grp: grp_reg, final_result: !item.stream_end};
            snap1_reg <= '{grp: grp_next, final_result: 1'b1};
        end
    end

    assign snap0_valid = snap0_valid_reg;
    assign snap0       = snap0_reg;
    assign snap1_valid = snap1_valid_reg;
    assign snap1       = snap1_reg;

endmodule

@@ sv/ksgc_outq.sv @@
// Result queue: takes up to two beats a cycle in order, gives one a cycle while ready is high.
// Depends on ksgc_pkg.
module ksgc_outq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr0,
    input  ksgc_pkg::out_beat_t data0,
    input  logic                wr1,
    input  ksgc_pkg::out_beat_t data1,
    output logic                valid,
    input  logic                ready,
    output ksgc_pkg::out_beat_t data,
    output logic [ksgc_pkg::OUTQ_CNT_W-1:0] level
);

    ksgc_pkg::out_beat_t                  mem [ksgc_pkg::OUTQ_DEPTH];
    logic [ksgc_pkg::OUTQ_PTR_W-1:0]      wp_reg;
    logic [ksgc_pkg::OUTQ_PTR_W-1:0]      rp_reg;
    logic [ksgc_pkg::OUTQ_CNT_W-1:0]      cnt_reg;
    logic [ksgc_pkg::OUTQ_CNT_W-1:0]      cnt_next;
    logic [ksgc_pkg::OUTQ_PTR_W-1:0]      wp1;
    logic                                 pop;

    assign pop      = valid && ready;
    assign wp1      = wp_reg + ksgc_pkg::OUTQ_PTR_W'(wr0);
    assign cnt_next = cnt_reg + ksgc_pkg::OUTQ_CNT_W'(wr0) + ksgc_pkg::OUTQ_CNT_W'(wr1)
                    - ksgc_pkg::OUTQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp1 + ksgc_pkg::OUTQ_PTR_W'(wr1);
            rp_reg  <= rp_reg + ksgc_pkg::OUTQ_PTR_W'(pop);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            mem[wp_reg] <= data0;
        end
        if (wr1)
        begin
            mem[wp1] <= data1;
        end
    end

    assign valid = (cnt_reg != '0);
    assign data  = mem[rp_reg];
    assign level = cnt_reg;

endmodule

@@ sv/ksgc_checker.sv @@
// Port-level checks for the sandwich k-mer group classifier, bound to the top.
// Depends on ksgc_pkg and kmer_sandwich_group_classifier.
module ksgc_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input ksgc_pkg::in_beat_t  in_beat,
    input logic                out_valid,
    input logic                out_ready,
    input ksgc_pkg::out_beat_t out_beat
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_beat))
        else $error("result beat changed while stalled");

    // every closed group holds at least one record
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_beat.group_size != 16'd0)
        else $error("empty group reported");

    // a stream end closes a group whose result is then offered on the out channel
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_beat.stream_end |-> ##2 out_valid)
        else $error("no result after stream end");

    // in_ready only drops while result beats are waiting in the queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind kmer_sandwich_group_classifier ksgc_checker u_ksgc_checker (.*);
